// ===== design/pdcchqd_pkg.sv =====
// Shared types and constants of the PDCCH quadruplet deinterleaver.
package pdcchqd_pkg;

    localparam int NUM_COL    = 32;
    localparam int COL_W      = 5;
    localparam int CELL_W     = 9;
    localparam int FIELD_W    = 16;
    localparam int NUM_COMP   = 8;
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 8;

    // Column order of the sub-block interleaver and its inverse.
    localparam logic [COL_W-1:0] PERM [NUM_COL] = '{
        5'd1,  5'd17, 5'd9,  5'd25, 5'd5,  5'd21, 5'd13, 5'd29,
        5'd3,  5'd19, 5'd11, 5'd27, 5'd7,  5'd23, 5'd15, 5'd31,
        5'd0,  5'd16, 5'd8,  5'd24, 5'd4,  5'd20, 5'd12, 5'd28,
        5'd2,  5'd18, 5'd10, 5'd26, 5'd6,  5'd22, 5'd14, 5'd30
    };

    localparam logic [COL_W-1:0] INV_PERM [NUM_COL] = '{
        5'd16, 5'd0,  5'd24, 5'd8,  5'd20, 5'd4,  5'd28, 5'd12,
        5'd18, 5'd2,  5'd26, 5'd10, 5'd22, 5'd6,  5'd30, 5'd14,
        5'd17, 5'd1,  5'd25, 5'd9,  5'd21, 5'd5,  5'd29, 5'd13,
        5'd19, 5'd3,  5'd27, 5'd11, 5'd23, 5'd7,  5'd31, 5'd15
    };

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_FETCH = 1'b1
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        logic    last;
    } t_cmd_ctl;

    typedef struct packed {
        logic [NUM_COMP-1:0][FIELD_W-1:0] sym;
        logic                             last;
        logic                             overflow;
    } t_result;

endpackage

// ===== design/pdcch_quadruplet_deinterleaver.sv =====
// PDCCH quadruplet deinterleaver: top level joining the input queue, the back end and the result queue.
//
// Words with cmd = 0 load one quadruplet each into a store of MAX_ROWS*32 entries; the load word with
// last_in = 1 closes the frame. Words with cmd = 1 fetch the deinterleaved quadruplets in order,
// one result per fetch, the last flagged; fetches with nothing to give produce no result. Loads
// and fetches are taken at up to one word per clock through a two-entry input queue, and results
// leave through an eight-entry queue, so either side may stall on its own. A fetch result passes the
// address pipeline (column lookup, row multiply, index sum, cyclic-shift wrap, registered store read)
// and then the result queue before it reaches the result ports. A load is held while a fetch address
// is still in the pipeline. After a frame closes, or after cell_id is written, fetches wait while a
// bit-serial unit forms cell_id mod Q. The store is not cleared after reset.
module pdcch_quadruplet_deinterleaver #(
    parameter int MAX_ROWS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pdcchqd_pkg::CELL_W-1:0]         i_cfg_cell_id,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   i_cmd,
    input  logic                                   i_last_in,
    input  logic signed [pdcchqd_pkg::FIELD_W-1:0] i_in_sym0_re,
    input  logic signed [pdcchqd_pkg::FIELD_W-1:0] i_in_sym0_im,
    input  logic signed [pdcchqd_pkg::FIELD_W-1:0] i_in_sym1_re,
    input  logic signed [pdcchqd_pkg::FIELD_W-1:0] i_in_sym1_im,
    input  logic signed [pdcchqd_pkg::FIELD_W-1:0] i_in_sym2_re,
    input  logic signed [pdcchqd_pkg::FIELD_W-1:0] i_in_sym2_im,
    input  logic signed [pdcchqd_pkg::FIELD_W-1:0] i_in_sym3_re,
    input  logic signed [pdcchqd_pkg::FIELD_W-1:0] i_in_sym3_im,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [pdcchqd_pkg::FIELD_W-1:0] o_out_sym0_re,
    output logic signed [pdcchqd_pkg::FIELD_W-1:0] o_out_sym0_im,
    output logic signed [pdcchqd_pkg::FIELD_W-1:0] o_out_sym1_re,
    output logic signed [pdcchqd_pkg::FIELD_W-1:0] o_out_sym1_im,
    output logic signed [pdcchqd_pkg::FIELD_W-1:0] o_out_sym2_re,
    output logic signed [pdcchqd_pkg::FIELD_W-1:0] o_out_sym2_im,
    output logic signed [pdcchqd_pkg::FIELD_W-1:0] o_out_sym3_re,
    output logic signed [pdcchqd_pkg::FIELD_W-1:0] o_out_sym3_im,
    output logic                                   o_last_out,
    output logic                                   o_overflow
);

    localparam int DW  = pdcchqd_pkg::NUM_COMP * SAMPLE_BITS;
    localparam int RSW = $bits(pdcchqd_pkg::t_result);

    logic [pdcchqd_pkg::NUM_COMP-1:0][pdcchqd_pkg::FIELD_W-1:0] samples;
    logic                   cmd_valid;
    pdcchqd_pkg::t_cmd_ctl  cmd_ctl;
    logic [DW-1:0]          cmd_data;
    logic                   cmd_take;
    logic                   res_push;
    pdcchqd_pkg::t_result   res_in;
    pdcchqd_pkg::t_result   res_out;
    logic [RSW-1:0]         outq_rdata;
    logic                   outq_full;
    logic [$clog2(pdcchqd_pkg::OUTQ_DEPTH+1)-1:0] outq_count;

    assign o_cfg_ready = 1'b1;

    assign samples[0] = i_in_sym0_re;
    assign samples[1] = i_in_sym0_im;
    assign samples[2] = i_in_sym1_re;
    assign samples[3] = i_in_sym1_im;
    assign samples[4] = i_in_sym2_re;
    assign samples[5] = i_in_sym2_im;
    assign samples[6] = i_in_sym3_re;
    assign samples[7] = i_in_sym3_im;

    pdcchqd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_cmd       (i_cmd),
        .i_last_in   (i_last_in),
        .i_samples   (samples),
        .o_cmd_valid (cmd_valid),
        .o_cmd_ctl   (cmd_ctl),
        .o_cmd_data  (cmd_data),
        .i_cmd_take  (cmd_take)
    );

    pdcchqd_back #(
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_cell_id (i_cfg_cell_id),
        .i_cmd_valid   (cmd_valid),
        .i_cmd_ctl     (cmd_ctl),
        .i_cmd_data    (cmd_data),
        .o_cmd_take    (cmd_take),
        .i_out_count   (outq_count),
        .o_res_push    (res_push),
        .o_res         (res_in)
    );

    pdcchqd_fifo #(
        .WIDTH (RSW),
        .DEPTH (pdcchqd_pkg::OUTQ_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (outq_full),
        .i_pop   (pop),
        .o_rdata (outq_rdata),
        .o_empty (empty),
        .o_count (outq_count)
    );

    assign res_out       = pdcchqd_pkg::t_result'(outq_rdata);
    assign o_out_sym0_re = res_out.sym[0];
    assign o_out_sym0_im = res_out.sym[1];
    assign o_out_sym1_re = res_out.sym[2];
    assign o_out_sym1_im = res_out.sym[3];
    assign o_out_sym2_re = res_out.sym[4];
    assign o_out_sym2_im = res_out.sym[5];
    assign o_out_sym3_re = res_out.sym[6];
    assign o_out_sym3_im = res_out.sym[7];
    assign o_last_out    = res_out.last;
    assign o_overflow    = res_out.overflow;

`ifndef ASSERT_OFF
    // The back end reserves room before it issues a fetch, so the result queue never overflows.
    a_no_result_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !outq_full)
        else $error("result word pushed into a full queue");

    // A word only leaves the input queue when one is waiting.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid)
        else $error("command word taken from an empty queue");

    // The configuration channel never stalls.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration word stalled");
`endif

endmodule

// ===== design/pdcchqd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pdcchqd_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pdcchqd_fifo.sv =====
// Small first-word-fall-through queue built from registers.
module pdcchqd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== design/pdcchqd_front.sv =====
// Input side: takes each word, classifies it and queues it for the back end.
module pdcchqd_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                                      i_clk,
    input  logic                                                      i_rst_n,
    input  logic                                                      i_push,
    output logic                                                      o_full,
    input  logic                                                      i_cmd,
    input  logic                                                      i_last_in,
    input  logic [pdcchqd_pkg::NUM_COMP-1:0][pdcchqd_pkg::FIELD_W-1:0] i_samples,
    output logic                                                      o_cmd_valid,
    output pdcchqd_pkg::t_cmd_ctl                                     o_cmd_ctl,
    output logic [pdcchqd_pkg::NUM_COMP*SAMPLE_BITS-1:0]              o_cmd_data,
    input  logic                                                      i_cmd_take
);

    localparam int DW = pdcchqd_pkg::NUM_COMP * SAMPLE_BITS;
    localparam int QW = $bits(pdcchqd_pkg::t_cmd_ctl) + DW;

    pdcchqd_pkg::t_cmd_ctl ctl;
    logic [DW-1:0]         data;
    logic                  q_empty;
    logic [QW-1:0]         q_rdata;
    logic [$clog2(pdcchqd_pkg::CMDQ_DEPTH+1)-1:0] q_count;

    // Each component is kept in SAMPLE_BITS bits, sign-extended or cut.
    always_comb begin
        logic signed [31:0] ext;
        ext      = '0;
        ctl.op   = i_cmd ? pdcchqd_pkg::CMD_FETCH : pdcchqd_pkg::CMD_LOAD;
        ctl.last = i_last_in;
        for (int k = 0; k < pdcchqd_pkg::NUM_COMP; k++) begin
            ext = 32'(signed'(i_samples[k]));
            data[k*SAMPLE_BITS +: SAMPLE_BITS] = ext[SAMPLE_BITS-1:0];
        end
    end

    pdcchqd_fifo #(
        .WIDTH (QW),
        .DEPTH (pdcchqd_pkg::CMDQ_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata ({ctl, data}),
        .o_full  (o_full),
        .i_pop   (i_cmd_take),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign o_cmd_valid = !q_empty && (q_count != '0);
    assign o_cmd_ctl   = pdcchqd_pkg::t_cmd_ctl'(q_rdata[QW-1:DW]);
    assign o_cmd_data  = q_rdata[DW-1:0];

endmodule

// ===== design/pdcchqd_back.sv =====
// Back end: sample store, frame counters, cell_id remainder unit and fetch address pipeline.
module pdcchqd_back #(
    parameter int MAX_ROWS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_valid,
    input  logic [pdcchqd_pkg::CELL_W-1:0]                  i_cfg_cell_id,
    input  logic                                            i_cmd_valid,
    input  pdcchqd_pkg::t_cmd_ctl                           i_cmd_ctl,
    input  logic [pdcchqd_pkg::NUM_COMP*SAMPLE_BITS-1:0]    i_cmd_data,
    output logic                                            o_cmd_take,
    input  logic [$clog2(pdcchqd_pkg::OUTQ_DEPTH+1)-1:0]    i_out_count,
    output logic                                            o_res_push,
    output pdcchqd_pkg::t_result                            o_res
);

    localparam int COL_W = pdcchqd_pkg::COL_W;
    localparam int CAP   = MAX_ROWS * pdcchqd_pkg::NUM_COL;
    localparam int QW    = $clog2(CAP + 1);
    localparam int AW    = $clog2(CAP);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int PW    = COL_W + RW;
    localparam int DW    = pdcchqd_pkg::NUM_COMP * SAMPLE_BITS;
    localparam int SW    = $clog2(pdcchqd_pkg::CELL_W);
    localparam int OCW   = $clog2(pdcchqd_pkg::OUTQ_DEPTH + 1);

    // Frame state and configuration.
    logic [pdcchqd_pkg::CELL_W-1:0] r_cell_id, n_cell_id;
    logic [QW-1:0]                  r_loaded, n_loaded;
    logic [QW-1:0]                  r_fetch_cnt, n_fetch_cnt;
    logic                           r_frame_ready, n_frame_ready;
    logic                           r_dropped, n_dropped;
    logic [RW-1:0]                  r_rows;
    logic [COL_W-1:0]               r_nulls;

    // Remainder unit for cell_id mod Q.
    logic                           r_mod_busy, n_mod_busy;
    logic [SW-1:0]                  r_mod_step, n_mod_step;
    logic [QW-1:0]                  r_rem, n_rem;
    logic [QW-1:0]                  r_qms, n_qms;
    logic [QW:0]                    rem_trial;
    logic [QW-1:0]                  rem_next;
    logic [SW-1:0]                  bit_idx;

    // Fetch pipeline.
    logic                           r_a_valid, r_b_valid, r_c_valid, r_e_valid;
    logic [RW-1:0]                  r_a_row;
    logic [COL_W-1:0]               r_a_jpos;
    logic                           r_a_null_col;
    logic                           r_a_last, r_a_ovf;
    logic [PW-1:0]                  r_b_prod;
    logic [COL_W:0]                 r_b_before;
    logic [RW-1:0]                  r_b_row;
    logic                           r_b_last, r_b_ovf;
    logic [AW-1:0]                  r_c_idx;
    logic                           r_c_last, r_c_ovf;
    logic                           r_e_last, r_e_ovf;

    logic                           is_fetch;
    logic                           front_busy;
    logic [2:0]                     inflight;
    logic                           credit_ok;
    logic                           ld_take;
    logic                           ld_fits;
    logic                           ld_we;
    logic                           close;
    logic                           restart;
    logic [QW-1:0]                  ld_base;
    logic                           fetch_ok;
    logic [QW-1:0]                  m_pos;
    logic [COL_W-1:0]               m_col;
    logic [pdcchqd_pkg::NUM_COL-1:0] sel;
    logic [PW-1:0]                  idx_full;
    logic [QW:0]                    src_sum;
    logic [QW:0]                    src_full;
    logic [AW-1:0]                  rd_addr;
    logic [DW-1:0]                  rd_data;

    assign is_fetch   = (i_cmd_ctl.op == pdcchqd_pkg::CMD_FETCH);
    assign front_busy = r_a_valid || r_b_valid || r_c_valid;
    assign inflight   = 3'(r_a_valid) + 3'(r_b_valid) + 3'(r_c_valid) + 3'(r_e_valid);
    assign credit_ok  = ((OCW+1)'(i_out_count) + (OCW+1)'(inflight))
                        < (OCW+1)'(pdcchqd_pkg::OUTQ_DEPTH);

    // A load waits until no fetch read is pending; a fetch waits for the shift, for no cell_id write and for room.
    assign o_cmd_take = i_cmd_valid &&
                        (is_fetch ? (!r_mod_busy && !i_cfg_valid && credit_ok) : !front_busy);

    assign ld_take  = o_cmd_take && !is_fetch;
    assign ld_base  = r_frame_ready ? '0 : r_loaded;
    assign ld_fits  = (ld_base < QW'(CAP));
    assign ld_we    = ld_take && ld_fits;
    assign close    = ld_take && i_cmd_ctl.last;
    assign restart  = i_cfg_valid || close;

    assign fetch_ok = o_cmd_take && is_fetch && r_frame_ready && (r_fetch_cnt < r_loaded);
    assign m_pos    = r_fetch_cnt + QW'(r_nulls);
    assign m_col    = m_pos[COL_W-1:0];

    assign bit_idx   = SW'(pdcchqd_pkg::CELL_W - 1) - r_mod_step;
    assign rem_trial = {r_rem, r_cell_id[bit_idx]};
    assign rem_next  = (rem_trial >= {1'b0, r_loaded}) ? QW'(rem_trial - {1'b0, r_loaded})
                                                        : QW'(rem_trial);

    always_comb begin
        n_cell_id     = i_cfg_valid ? i_cfg_cell_id : r_cell_id;
        n_loaded      = r_loaded;
        n_fetch_cnt   = r_fetch_cnt;
        n_frame_ready = r_frame_ready;
        n_dropped     = r_dropped;
        if (ld_take) begin
            n_loaded      = ld_fits ? ld_base + 1'b1 : ld_base;
            n_dropped     = (r_dropped && !r_frame_ready) || !ld_fits;
            n_frame_ready = i_cmd_ctl.last;
            n_fetch_cnt   = '0;
        end else if (fetch_ok) begin
            n_fetch_cnt = r_fetch_cnt + 1'b1;
        end

        n_mod_busy = r_mod_busy;
        n_mod_step = r_mod_step;
        n_rem      = r_rem;
        n_qms      = r_qms;
        if (restart) begin
            n_mod_busy = 1'b1;
            n_mod_step = '0;
            n_rem      = '0;
        end else if (r_mod_busy) begin
            n_rem      = rem_next;
            n_mod_step = r_mod_step + 1'b1;
            if (r_mod_step == SW'(pdcchqd_pkg::CELL_W - 1)) begin
                n_mod_busy = 1'b0;
                n_qms      = r_loaded - rem_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_id     <= '0;
            r_loaded      <= '0;
            r_fetch_cnt   <= '0;
            r_frame_ready <= 1'b0;
            r_dropped     <= 1'b0;
            r_mod_busy    <= 1'b0;
            r_mod_step    <= '0;
            r_a_valid     <= 1'b0;
            r_b_valid     <= 1'b0;
            r_c_valid     <= 1'b0;
            r_e_valid     <= 1'b0;
        end else begin
            r_cell_id     <= n_cell_id;
            r_loaded      <= n_loaded;
            r_fetch_cnt   <= n_fetch_cnt;
            r_frame_ready <= n_frame_ready;
            r_dropped     <= n_dropped;
            r_mod_busy    <= n_mod_busy;
            r_mod_step    <= n_mod_step;
            r_a_valid     <= fetch_ok;
            r_b_valid     <= r_a_valid;
            r_c_valid     <= r_b_valid;
            r_e_valid     <= r_c_valid;
        end
    end

    // Matrix geometry is fixed when the frame closes.
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_qms <= n_qms;
        if (close) begin
            r_rows  <= RW'(({1'b0, n_loaded} + (QW+1)'(pdcchqd_pkg::NUM_COL - 1)) >> COL_W);
            r_nulls <= COL_W'(QW'(0) - n_loaded);
        end
    end

    always_comb begin
        for (int k = 0; k < pdcchqd_pkg::NUM_COL; k++) begin
            sel[k] = (COL_W'(k) < r_a_jpos) && (pdcchqd_pkg::PERM[k] < r_nulls);
        end
    end

    assign idx_full = r_b_prod - PW'(r_b_before) + PW'(r_b_row);
    assign src_sum  = (QW+1)'(r_c_idx) + (QW+1)'(r_qms);
    assign src_full = (src_sum >= {1'b0, r_loaded}) ? src_sum - {1'b0, r_loaded} : src_sum;
    assign rd_addr  = AW'(src_full);

    always_ff @(posedge i_clk) begin
        r_a_row      <= RW'(m_pos >> COL_W);
        r_a_jpos     <= pdcchqd_pkg::INV_PERM[m_col];
        r_a_null_col <= (m_col < r_nulls);
        r_a_last     <= ((r_fetch_cnt + 1'b1) == r_loaded);
        r_a_ovf      <= r_dropped;

        r_b_prod     <= PW'(r_a_jpos) * PW'(r_rows);
        r_b_before   <= (COL_W+1)'($countones(sel));
        r_b_row      <= r_a_row - RW'(r_a_null_col);
        r_b_last     <= r_a_last;
        r_b_ovf      <= r_a_ovf;

        r_c_idx      <= AW'(idx_full);
        r_c_last     <= r_b_last;
        r_c_ovf      <= r_b_ovf;

        r_e_last     <= r_c_last;
        r_e_ovf      <= r_c_ovf;
    end

    pdcchqd_ram #(
        .WIDTH (DW),
        .DEPTH (CAP)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (ld_base[AW-1:0]),
        .i_wdata (i_cmd_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        logic signed [31:0] ext;
        ext = '0;
        for (int k = 0; k < pdcchqd_pkg::NUM_COMP; k++) begin
            ext          = 32'(signed'(rd_data[k*SAMPLE_BITS +: SAMPLE_BITS]));
            o_res.sym[k] = ext[pdcchqd_pkg::FIELD_W-1:0];
        end
        o_res.last     = r_e_last;
        o_res.overflow = r_e_ovf;
    end

    assign o_res_push = r_e_valid;

`ifndef ASSERT_OFF
    // The fetch counter never runs past the number of stored words.
    a_fetch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch_cnt <= r_loaded)
        else $error("fetch count passed the loaded count");

    // A result is only produced when the output queue has room for it.
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (i_out_count < OCW'(pdcchqd_pkg::OUTQ_DEPTH)))
        else $error("result pushed into a full output queue");

    // No load may reopen the frame while a fetch address is still being worked out.
    a_frame_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid || r_b_valid || r_c_valid) |-> r_frame_ready)
        else $error("frame reopened under a pending fetch");

    // Closing a frame starts the remainder unit.
    a_close_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close |=> (r_mod_busy && r_frame_ready))
        else $error("frame close did not start the shift computation");
`endif

endmodule
